// ===== rtl/stick_setpoint_generator_top_macros.svh =====
// Assertion macros shared by the stick setpoint generator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef STICK_SETPOINT_GENERATOR_TOP_MACROS_SVH
`define STICK_SETPOINT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stick setpoint generator: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stick setpoint generator: next-cycle check failed");

`endif

// ===== rtl/ssg_pkg.sv =====
// Types, codes, constants and fixed-point helpers for the stick setpoint generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssg_pkg;

	// Item request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_RANGE   = 2'd1;
	localparam logic [1:0] REQ_ARM     = 2'd2;
	localparam logic [1:0] REQ_TAKEOFF = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_DEADBAND      = 3'd0;
	localparam logic [2:0] CFG_XY_GAIN       = 3'd1;
	localparam logic [2:0] CFG_Z_GAIN        = 3'd2;
	localparam logic [2:0] CFG_YAW_GAIN      = 3'd3;
	localparam logic [2:0] CFG_RANGE_LIMIT   = 3'd4;
	localparam logic [2:0] CFG_STEP_UP       = 3'd5;
	localparam logic [2:0] CFG_STEP_DOWN     = 3'd6;
	localparam logic [2:0] CFG_DESCENT_LIMIT = 3'd7;

	// Register reset values
	localparam logic [14:0]        RST_DEADBAND      = 15'd1638;
	localparam logic [15:0]        RST_XY_GAIN       = 16'd640;
	localparam logic [15:0]        RST_Z_GAIN        = 16'd7680;
	localparam logic signed [15:0] RST_YAW_GAIN      = -16'sd128;
	localparam logic [15:0]        RST_RANGE_LIMIT   = 16'd2000;
	localparam logic [7:0]         RST_STEP_UP       = 8'd1;
	localparam logic [7:0]         RST_STEP_DOWN     = 8'd5;
	localparam logic signed [16:0] RST_DESCENT_LIMIT = -17'sd20;

	// Altitude hold length in ticks, and landing speed after reset
	localparam logic [6:0]  HOLD_TICKS          = 7'd100;
	localparam logic [15:0] LANDING_SPEED_RESET = 16'd50;

	typedef struct packed {
		logic [14:0]        deadband;
		logic [15:0]        xy_gain;
		logic [15:0]        z_gain;
		logic signed [15:0] yaw_gain;
		logic [15:0]        range_limit;
		logic [7:0]         step_up;
		logic [7:0]         step_down;
		logic signed [16:0] descent_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] stick_roll;
		logic signed [15:0] stick_pitch;
		logic signed [15:0] stick_yaw;
		logic signed [15:0] stick_alt;
		logic               manual_mode;
		logic               landing_now;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        downward_range;
	} item_t;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] yaw_rate;
		logic signed [31:0] takeoff_speed;
		logic [15:0]        landing_speed;
	} result_t;

	// Sign-extend a Q16.16 value to the 35-bit sum width
	function automatic logic [34:0] sx35(input logic [31:0] v);
		return {{3{v[31]}}, v};
	endfunction

	// Clamp a 35-bit two's complement sum to 32 bits
	function automatic logic [31:0] sat32(input logic [34:0] v);
		logic [31:0] r;
		r = v[31:0];
		if (!v[34] && (v[33:31] != 3'b000)) begin
			r = 32'h7FFF_FFFF;
		end else if (v[34] && (v[33:31] != 3'b111)) begin
			r = 32'h8000_0000;
		end
		return r;
	endfunction

	// |stick| strictly above the deadband
	function automatic logic past_deadband(input logic [15:0] s, input logic [14:0] db);
		logic [16:0] a;
		a = s[15] ? (17'd0 - {1'b1, s}) : {1'b0, s};
		return a > {2'b00, db};
	endfunction

	// Q1.14 stick times Q8.8 gain, back to Q16.16: round half up, drop 6 bits
	function automatic logic [27:0] scale_stick(input logic [15:0] s, input logic [16:0] g);
		logic [33:0] p;
		p = {{18{s[15]}}, s} * {{17{g[16]}}, g};
		p = p + 34'd32;
		return p[33:6];
	endfunction

	function automatic logic [34:0] sx_scale(input logic [27:0] v);
		return {{7{v[27]}}, v};
	endfunction

endpackage

// ===== rtl/ssg_cfg.sv =====
// Configuration register file for the stick setpoint generator.
// Depends on ssg_pkg for cfg_t, register indexes and reset values.
`timescale 1ns / 1ps

module ssg_cfg import ssg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [16:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband      <= RST_DEADBAND;
			cfg_q.xy_gain       <= RST_XY_GAIN;
			cfg_q.z_gain        <= RST_Z_GAIN;
			cfg_q.yaw_gain      <= RST_YAW_GAIN;
			cfg_q.range_limit   <= RST_RANGE_LIMIT;
			cfg_q.step_up       <= RST_STEP_UP;
			cfg_q.step_down     <= RST_STEP_DOWN;
			cfg_q.descent_limit <= RST_DESCENT_LIMIT;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DEADBAND:      cfg_q.deadband      <= wr_data[14:0];
				CFG_XY_GAIN:       cfg_q.xy_gain       <= wr_data[15:0];
				CFG_Z_GAIN:        cfg_q.z_gain        <= wr_data[15:0];
				CFG_YAW_GAIN:      cfg_q.yaw_gain      <= wr_data[15:0];
				CFG_RANGE_LIMIT:   cfg_q.range_limit   <= wr_data[15:0];
				CFG_STEP_UP:       cfg_q.step_up       <= wr_data[7:0];
				CFG_STEP_DOWN:     cfg_q.step_down     <= wr_data[7:0];
				CFG_DESCENT_LIMIT: cfg_q.descent_limit <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ssg_axis.sv =====
// Next-state logic of one horizontal axis: offset latch, stick nudge, settle on release.
// Depends on ssg_pkg for the fixed-point helpers.
`timescale 1ns / 1ps

module ssg_axis import ssg_pkg::*; (
	input  logic               enable,
	input  logic signed [15:0] stick,
	input  logic signed [31:0] pos,
	input  logic signed [31:0] target,
	input  logic signed [31:0] offset,
	input  logic               held,
	input  logic [15:0]        gain,
	input  logic [14:0]        deadband,
	output logic signed [31:0] target_next,
	output logic signed [31:0] offset_next,
	output logic               held_next
);

	logic [31:0] off_use;
	logic [27:0] nudge;

	always_comb begin
		// latch the offset on the first deflected tick, then use it at once
		off_use     = held ? offset : sat32(sx35(target) - sx35(pos));
		nudge       = scale_stick(stick, {1'b0, gain});
		target_next = target;
		offset_next = offset;
		held_next   = held;
		if (enable) begin
			if (past_deadband(stick, deadband)) begin
				offset_next = off_use;
				held_next   = 1'b1;
				target_next = sat32(sx35(pos) + sx35(off_use) + sx_scale(nudge));
			end else if (held) begin
				target_next = sat32(sx35(pos) + sx35(offset));
				held_next   = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ssg_engine.sv =====
// Setpoint state and its single-pass update for one item.
// Depends on ssg_pkg, ssg_axis and the assertion macro header.
`timescale 1ns / 1ps
`include "stick_setpoint_generator_top_macros.svh"

module ssg_engine import ssg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam logic [16:0] TAKEOFF_RECIP = 17'd41944;  // ceil(2^21 / 50)

	logic [31:0] tgt_q [3];
	logic [31:0] off_q [3];
	logic        pitch_held_q;
	logic        roll_held_q;
	logic [6:0]  cnt_q;
	logic [31:0] takeoff_q;
	logic [15:0] ds_q;
	logic [15:0] prev_q;
	logic [31:0] yaw_q;

	logic [31:0] tgt_n [3];
	logic [31:0] off_n [3];
	logic        pitch_held_n;
	logic        roll_held_n;
	logic [6:0]  cnt_n;
	logic [31:0] takeoff_n;
	logic [15:0] ds_n;
	logic [15:0] prev_n;
	logic [31:0] yaw_n;

	logic        tick_auto;
	logic [31:0] ax_tgt [2];
	logic [31:0] ax_off [2];
	logic [27:0] yaw_scaled;
	logic [27:0] z_nudge;
	logic [31:0] z_off_use;
	logic [16:0] alt_abs;
	logic [33:0] inc_prod;
	logic [12:0] inc_mag;
	logic [31:0] inc_signed;
	logic [16:0] ds_up;
	logic [16:0] range_diff;

	assign tick_auto = (item.req_type == REQ_TICK) && !item.manual_mode;

	ssg_axis u_axis_x (
		.enable      (tick_auto),
		.stick       (item.stick_pitch),
		.pos         (item.pos_x),
		.target      (tgt_q[0]),
		.offset      (off_q[0]),
		.held        (pitch_held_q),
		.gain        (cfg.xy_gain),
		.deadband    (cfg.deadband),
		.target_next (ax_tgt[0]),
		.offset_next (ax_off[0]),
		.held_next   (pitch_held_n)
	);

	ssg_axis u_axis_y (
		.enable      (tick_auto),
		.stick       (item.stick_roll),
		.pos         (item.pos_y),
		.target      (tgt_q[1]),
		.offset      (off_q[1]),
		.held        (roll_held_q),
		.gain        (cfg.xy_gain),
		.deadband    (cfg.deadband),
		.target_next (ax_tgt[1]),
		.offset_next (ax_off[1]),
		.held_next   (roll_held_n)
	);

	always_comb begin
		yaw_scaled = scale_stick(item.stick_yaw, {cfg.yaw_gain[15], cfg.yaw_gain});
		z_nudge    = scale_stick(item.stick_alt, {1'b0, cfg.z_gain});
		z_off_use  = (cnt_q == 7'd0) ? sat32(sx35(tgt_q[2]) - sx35(item.pos_z)) : off_q[2];
		// stick/50 rounded half away from zero: (|alt| + 25) / 50 by reciprocal
		alt_abs    = item.stick_alt[15] ? (17'd0 - {1'b1, item.stick_alt})
		                                : {1'b0, item.stick_alt};
		inc_prod   = 34'(alt_abs + 17'd25) * 34'(TAKEOFF_RECIP);
		inc_mag    = inc_prod[33:21];
		inc_signed = item.stick_alt[15] ? (32'd0 - 32'(inc_mag)) : 32'(inc_mag);
		ds_up      = {1'b0, ds_q} + {9'd0, cfg.step_up};
		range_diff = {1'b0, item.downward_range} - {1'b0, prev_q};

		tgt_n[0]  = tgt_q[0];
		tgt_n[1]  = tgt_q[1];
		tgt_n[2]  = tgt_q[2];
		off_n[0]  = off_q[0];
		off_n[1]  = off_q[1];
		off_n[2]  = off_q[2];
		cnt_n     = cnt_q;
		takeoff_n = takeoff_q;
		ds_n      = ds_q;
		prev_n    = prev_q;
		yaw_n     = yaw_q;

		case (item.req_type)
			REQ_TICK: begin
				yaw_n = past_deadband(item.stick_yaw, cfg.deadband)
				        ? {{4{yaw_scaled[27]}}, yaw_scaled} : 32'd0;
				if (item.manual_mode) begin
					if (past_deadband(item.stick_alt, cfg.deadband)) begin
						takeoff_n = sat32(sx35(takeoff_q) + sx35(inc_signed));
					end
				end else begin
					tgt_n[0] = ax_tgt[0];
					off_n[0] = ax_off[0];
					tgt_n[1] = ax_tgt[1];
					off_n[1] = ax_off[1];
					if (item.landing_now) begin
						tgt_n[2] = sat32(sx35(item.pos_z) + sx35(off_q[2])
						                 - {3'b000, ds_q, 16'd0});
					end else if (past_deadband(item.stick_alt, cfg.deadband)) begin
						// a press during the countdown keeps the old offset
						off_n[2] = z_off_use;
						if (cnt_q == 7'd0) begin
							cnt_n = HOLD_TICKS;
						end
						tgt_n[2] = sat32(sx35(item.pos_z) + sx35(z_off_use) + sx_scale(z_nudge));
					end else if (cnt_q != 7'd0) begin
						tgt_n[2] = sat32(sx35(item.pos_z) + sx35(off_q[2]));
						cnt_n    = cnt_q - 7'd1;
					end
				end
			end
			REQ_RANGE: begin
				if (item.landing_now) begin
					if (item.downward_range < cfg.range_limit) begin
						if (!range_diff[16]) begin
							ds_n = ds_up[16] ? 16'hFFFF : ds_up[15:0];
						end else if ($signed(range_diff) < cfg.descent_limit) begin
							ds_n = (ds_q > {8'd0, cfg.step_down})
							       ? ds_q - {8'd0, cfg.step_down} : 16'd0;
						end
					end
					prev_n = item.downward_range;
				end
			end
			REQ_ARM, REQ_TAKEOFF: begin
				tgt_n[0] = item.pos_x;
				tgt_n[1] = item.pos_y;
				tgt_n[2] = item.pos_z;
				off_n[0] = 32'd0;
				off_n[1] = 32'd0;
				off_n[2] = 32'd0;
				if (item.req_type == REQ_ARM) begin
					takeoff_n = 32'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[0]     <= 32'd0;
			tgt_q[1]     <= 32'd0;
			tgt_q[2]     <= 32'd0;
			off_q[0]     <= 32'd0;
			off_q[1]     <= 32'd0;
			off_q[2]     <= 32'd0;
			pitch_held_q <= 1'b0;
			roll_held_q  <= 1'b0;
			cnt_q        <= 7'd0;
			takeoff_q    <= 32'd0;
			ds_q         <= LANDING_SPEED_RESET;
			prev_q       <= 16'd0;
			yaw_q        <= 32'd0;
		end else if (go) begin
			tgt_q[0]     <= tgt_n[0];
			tgt_q[1]     <= tgt_n[1];
			tgt_q[2]     <= tgt_n[2];
			off_q[0]     <= off_n[0];
			off_q[1]     <= off_n[1];
			off_q[2]     <= off_n[2];
			pitch_held_q <= pitch_held_n;
			roll_held_q  <= roll_held_n;
			cnt_q        <= cnt_n;
			takeoff_q    <= takeoff_n;
			ds_q         <= ds_n;
			prev_q       <= prev_n;
			yaw_q        <= yaw_n;
		end
	end

	assign res.target_x      = tgt_n[0];
	assign res.target_y      = tgt_n[1];
	assign res.target_z      = tgt_n[2];
	assign res.yaw_rate      = yaw_n;
	assign res.takeoff_speed = takeoff_n;
	assign res.landing_speed = ds_n;

	`SSG_ASSERT_NOW(a_hold_bound, 1'b1, cnt_q <= HOLD_TICKS)
	`SSG_ASSERT_NEXT(a_realign_clears, go && (item.req_type == REQ_ARM || item.req_type == REQ_TAKEOFF), off_q[0] == 32'd0 && off_q[1] == 32'd0 && off_q[2] == 32'd0)
	`SSG_ASSERT_NEXT(a_range_keeps, go && item.req_type == REQ_RANGE, $stable(takeoff_q) && $stable(tgt_q[2]))

endmodule

// ===== rtl/stick_setpoint_generator_top.sv =====
// Top level of the stick setpoint generator: handshakes, input and result registers.
// Depends on ssg_pkg, ssg_cfg, ssg_engine and the assertion macro header.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  req_type, sticks, modes, pos_*, range
//   out      source     out_valid/out_stall  target_*, yaw_rate, takeoff/landing speed
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the input
// register, then the result register. The setpoint state updates in the same cycle
// the item leaves the input register, so the next item sees it without a gap. Reset
// sets valid and state registers at once, no sweep needed; payload data has no reset.
// A stalled result holds its register; the input register keeps taking items
// while the result register drains, and in_stall rises only when both are full.
// cfg_ready is always high; write configuration only while the block is idle.
`timescale 1ns / 1ps
`include "stick_setpoint_generator_top_macros.svh"

module stick_setpoint_generator_top import ssg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] stick_roll,
	input  logic signed [15:0] stick_pitch,
	input  logic signed [15:0] stick_yaw,
	input  logic signed [15:0] stick_alt,
	input  logic               manual_mode,
	input  logic               landing_now,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0]        downward_range,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] target_x,
	output logic signed [31:0] target_y,
	output logic signed [31:0] target_z,
	output logic signed [31:0] yaw_rate,
	output logic signed [31:0] takeoff_speed,
	output logic [15:0]        landing_speed,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    s1_valid;
	logic    advance;
	logic    load_s1;
	logic    out_valid_q;
	result_t res_next;
	result_t res_q;

	assign cfg_ready = 1'b1;

	ssg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the held item when the result register is empty or being drained
	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (load_s1) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	// input payload needs no reset
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.req_type       <= req_type;
			item_s1.stick_roll     <= stick_roll;
			item_s1.stick_pitch    <= stick_pitch;
			item_s1.stick_yaw      <= stick_yaw;
			item_s1.stick_alt      <= stick_alt;
			item_s1.manual_mode    <= manual_mode;
			item_s1.landing_now    <= landing_now;
			item_s1.pos_x          <= pos_x;
			item_s1.pos_y          <= pos_y;
			item_s1.pos_z          <= pos_z;
			item_s1.downward_range <= downward_range;
		end
	end

	ssg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	// drop the result once taken, unless a new item replaces it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign target_x      = res_q.target_x;
	assign target_y      = res_q.target_y;
	assign target_z      = res_q.target_z;
	assign yaw_rate      = res_q.yaw_rate;
	assign takeoff_speed = res_q.takeoff_speed;
	assign landing_speed = res_q.landing_speed;

	`SSG_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid)
	`SSG_ASSERT_NEXT(a_stall_keeps_item, in_stall, s1_valid)
	`SSG_ASSERT_NOW(a_result_from_item, $rose(out_valid_q), $past(s1_valid))
	`SSG_ASSERT_NEXT(a_drain_empties, out_valid_q && !out_stall && !s1_valid, !out_valid_q)

endmodule
